// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication, sampled on clk, muted in reset
`define CHK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Command and status codes of the stable priority queue.
// ----------------------------------------------------------------------------
`default_nettype none
package spq_pkg;
    localparam logic [1:0] CMD_ENQ  = 2'd0;
    localparam logic [1:0] CMD_DEQ  = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/core/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded sorted priority queue, FIFO order among equal priorities.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command per beat:
//   enqueue (data_in, priority_in), dequeue front, or peek front. Code 3
//   acts as a peek. Every beat yields exactly one result beat on the output
//   channel (out_valid / out_stall): status, front data and priority
//   (zero for enqueue and empty), and the entry count after the command.
//   Entries live in a circular buffer in one RAM, sorted front first.
//   Dequeue and peek make one RAM read of the front entry; on an empty
//   store they make none.
//   Enqueue walks from the tail toward the front, moving one lower-priority
//   entry back per cycle, passing up to CAPACITY-1 entries; a refused or
//   empty-store enqueue goes straight to the result without a walk.
//   One command is in flight at a time; the next is taken once the result
//   is loaded into the output register, which holds while out_stall is high.
//   Reset empties the queue at once (count and head; the RAM is not
//   cleared); RAM contents are never read before they are written.
// ----------------------------------------------------------------------------
`default_nettype none
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY      = 64,
    parameter int DATA_BITS     = 32,
    parameter int PRIORITY_BITS = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [1:0]               command,
    input  wire logic [DATA_BITS-1:0]     data_in,
    input  wire logic [PRIORITY_BITS-1:0] priority_in,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [1:0]                    status,
    output logic [DATA_BITS-1:0]          data_out,
    output logic [PRIORITY_BITS-1:0]      priority_out,
    output logic [6:0]                    count
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = PRIORITY_BITS + DATA_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_FRONT,
        S_CMP,
        S_PLACE,
        S_RESULT
    } state_t;

    state_t                   state_reg;
    logic [1:0]               cmd_reg;
    logic [DATA_BITS-1:0]     new_data_reg;
    logic [PRIORITY_BITS-1:0] new_prio_reg;
    logic [AW-1:0]            head_reg;
    logic [CW-1:0]            count_reg;
    logic [AW-1:0]            hole_reg;     // physical slot now free
    logic [CW-1:0]            hole_cnt_reg; // its logical index
    logic [1:0]               res_status_reg;
    logic [DATA_BITS-1:0]     res_data_reg;
    logic [PRIORITY_BITS-1:0] res_prio_reg;
    logic                     out_valid_reg;
    logic [1:0]               status_reg;
    logic [DATA_BITS-1:0]     data_out_reg;
    logic [PRIORITY_BITS-1:0] prio_out_reg;
    logic [CW-1:0]            count_out_reg;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [MW-1:0]            mem_wdata;
    logic                     mem_re;
    logic [AW-1:0]            mem_raddr;
    logic [MW-1:0]            mem_rdata;
    logic [PRIORITY_BITS-1:0] rd_prio;
    logic [DATA_BITS-1:0]     rd_data;
    logic [AW:0]              tail_sum;
    logic [AW-1:0]            tail_phys;
    logic                     moves_back;
    logic [CW+6:0]            count_ext;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == AW'(CAPACITY - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] a);
        return (a == '0) ? AW'(CAPACITY - 1) : a - 1'b1;
    endfunction

    assign rd_prio    = mem_rdata[MW-1:DATA_BITS];
    assign rd_data    = mem_rdata[DATA_BITS-1:0];
    assign tail_sum   = {1'b0, head_reg} + (AW+1)'(count_reg);
    assign tail_phys  = (tail_sum >= (AW+1)'(CAPACITY)) ?
                        AW'(tail_sum - (AW+1)'(CAPACITY)) : tail_sum[AW-1:0];
    // new entry goes ahead of strictly lower priorities only
    assign moves_back = new_prio_reg > rd_prio;

    // RAM port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = hole_reg;
        mem_wdata = {new_prio_reg, new_data_reg};
        mem_re    = 1'b0;
        mem_raddr = wrap_dec(tail_phys);
        case (state_reg)
            S_DISPATCH:
            begin
                if (cmd_reg == CMD_ENQ)
                begin
                    if (count_reg == '0)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = head_reg;
                    end
                    else if (count_reg != CW'(CAPACITY))
                    begin
                        mem_re = 1'b1;
                    end
                end
                else if (count_reg != '0)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = head_reg;
                end
            end
            S_CMP:
            begin
                mem_we = 1'b1;
                if (moves_back)
                begin
                    mem_wdata = mem_rdata;
                    mem_re    = (hole_cnt_reg != CW'(1));
                    mem_raddr = wrap_dec(wrap_dec(hole_reg));
                end
            end
            S_PLACE:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    spq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (MW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // S_RESULT owns out_valid_reg in its own cycle
            if (out_valid_reg && !out_stall && state_reg != S_RESULT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg      <= command;
                        new_data_reg <= data_in;
                        new_prio_reg <= priority_in;
                        state_reg    <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    res_data_reg <= '0;
                    res_prio_reg <= '0;
                    hole_reg     <= tail_phys;
                    hole_cnt_reg <= count_reg;
                    if (cmd_reg == CMD_ENQ)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            res_status_reg <= ST_FULL;
                            state_reg      <= S_RESULT;
                        end
                        else if (count_reg == '0)
                        begin
                            count_reg      <= count_reg + 1'b1;
                            res_status_reg <= ST_OK;
                            state_reg      <= S_RESULT;
                        end
                        else
                        begin
                            state_reg <= S_CMP;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_status_reg <= ST_EMPTY;
                        state_reg      <= S_RESULT;
                    end
                    else
                    begin
                        state_reg <= S_FRONT;
                    end
                end
                S_FRONT:
                begin
                    res_status_reg <= ST_OK;
                    res_data_reg   <= rd_data;
                    res_prio_reg   <= rd_prio;
                    if (cmd_reg == CMD_DEQ)
                    begin
                        head_reg  <= wrap_inc(head_reg);
                        count_reg <= count_reg - 1'b1;
                    end
                    state_reg <= S_RESULT;
                end
                S_CMP:
                begin
                    res_status_reg <= ST_OK;
                    if (moves_back)
                    begin
                        hole_reg     <= wrap_dec(hole_reg);
                        hole_cnt_reg <= hole_cnt_reg - 1'b1;
                        if (hole_cnt_reg == CW'(1))
                        begin
                            state_reg <= S_PLACE;
                        end
                    end
                    else
                    begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_RESULT;
                    end
                end
                S_PLACE:
                begin
                    count_reg <= count_reg + 1'b1;
                    state_reg <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= res_status_reg;
                        data_out_reg  <= res_data_reg;
                        prio_out_reg  <= res_prio_reg;
                        count_out_reg <= count_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign count_ext    = {7'b0, count_out_reg};
    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign data_out     = data_out_reg;
    assign priority_out = prio_out_reg;
    assign count        = count_ext[6:0];
endmodule
`default_nettype wire

// ===== rtl/core/spq_ram.sv =====
// ----------------------------------------------------------------------------
// spq_ram
// Simple dual-port entry store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module spq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 48
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the stable priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module spq_checker
    import spq_pkg::*;
#(
    parameter int CAPACITY      = 64,
    parameter int DATA_BITS     = 32,
    parameter int PRIORITY_BITS = 16
) (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     in_valid,
    input wire logic                     in_stall,
    input wire logic [1:0]               command,
    input wire logic [DATA_BITS-1:0]     data_in,
    input wire logic [PRIORITY_BITS-1:0] priority_in,
    input wire logic                     out_valid,
    input wire logic                     out_stall,
    input wire logic [1:0]               status,
    input wire logic [DATA_BITS-1:0]     data_out,
    input wire logic [PRIORITY_BITS-1:0] priority_out,
    input wire logic [6:0]               count
);
    localparam int CAP_LOW = CAPACITY % 128;

    `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(count), "stalled result beat changed")
    `CHK_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(command) && $stable(data_in) && $stable(priority_in), "stalled command beat changed")
    `CHK_IMPL(a_full_count, out_valid && status == ST_FULL, count == CAP_LOW[6:0], "full status with count below capacity")
    `CHK_IMPL(a_empty_zero, out_valid && status == ST_EMPTY, count == 7'd0 && data_out == '0 && priority_out == '0, "empty result not zero")
endmodule

bind stable_priority_queue spq_checker #(
    .CAPACITY      (CAPACITY),
    .DATA_BITS     (DATA_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
) u_spq_checker (.*);
`default_nettype wire

// ===== tb/tb_stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// tb_stable_priority_queue
// Self-checking bench for the stable priority queue: a table of directed
// commands, then bursts of random fill/drain traffic, all scored against a
// sorted-array model of the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_stable_priority_queue;
    import spq_pkg::*;

    localparam int DEPTH = 64;
    localparam int CMD_ODD = 3;      // unused code, acts as a peek
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [1:0]  st;
        logic [31:0] data;
        logic [15:0] prio;
        logic [6:0]  cnt;
    } result_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] data;
        logic [15:0] prio;
        bit          typed;   // expected result written in the row
        result_t     res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [31:0] data_in;
    logic [15:0] priority_in;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [31:0] data_out;
    logic [15:0] priority_out;
    logic [6:0]  count;

    stable_priority_queue DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .data_in(data_in), .priority_in(priority_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .data_out(data_out), .priority_out(priority_out),
        .count(count)
    );

    // shadow queue, front at index 0
    logic [15:0] held_prio[DEPTH];
    logic [31:0] held_data[DEPTH];
    int          held_n;

    result_t pending_results[$];
    int      errors;
    int      cycles;
    bit      long_hold;   // asks the receiver for one long hold-off
    bit      stim_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Queue model: stable insert, front removal. Returns the result it yields.
    function automatic result_t queue_apply(logic [1:0] cmd, logic [31:0] d,
                                            logic [15:0] p);
        result_t r;
        int      pos;
        r = '0;
        if (cmd == CMD_ENQ)
        begin
            if (held_n >= DEPTH)
                r.st = ST_FULL;
            else
            begin
                pos = held_n;
                for (int i = 0; i < held_n; i++)
                    if (p > held_prio[i])
                    begin
                        pos = i;
                        break;
                    end
                for (int i = held_n; i > pos; i--)
                begin
                    held_prio[i] = held_prio[i-1];
                    held_data[i] = held_data[i-1];
                end
                held_prio[pos] = p;
                held_data[pos] = d;
                held_n++;
                r.st = ST_OK;
            end
        end
        else if (held_n == 0)
            r.st = ST_EMPTY;
        else
        begin
            r.st   = ST_OK;
            r.data = held_data[0];
            r.prio = held_prio[0];
            if (cmd == CMD_DEQ)
            begin
                for (int i = 1; i < held_n; i++)
                begin
                    held_prio[i-1] = held_prio[i];
                    held_data[i-1] = held_data[i];
                end
                held_n--;
            end
        end
        r.cnt = held_n[6:0];
        return r;
    endfunction

    // Send one beat; record its expected result at acceptance.
    task automatic send_beat(logic [1:0] cmd, logic [31:0] d, logic [15:0] p,
                             bit typed, result_t want);
        result_t model;
        in_valid    <= 1'b1;
        command     <= cmd;
        data_in     <= d;
        priority_in <= p;
        do
            @(posedge clk);
        while (in_stall);
        model = queue_apply(cmd, d, p);
        if (typed && model !== want)
        begin
            errors++;
            if (errors <= 10)
                $display("table row disagrees with model: row %h model %h", want, model);
        end
        pending_results.push_back(model);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
    endtask

    // Random command mix; bias toward enqueue or dequeue to sweep fill level.
    task automatic random_beat(int enq_pct);
        logic [1:0]  cmd;
        logic [15:0] p;
        int          roll;
        roll = $urandom_range(99);
        if (roll < enq_pct)
            cmd = CMD_ENQ;
        else if (roll < enq_pct + (100 - enq_pct) * 3 / 4)
            cmd = CMD_DEQ;
        else if ($urandom_range(3) == 0)
            cmd = 2'(CMD_ODD);
        else
            cmd = CMD_PEEK;
        // few distinct priorities so ties (FIFO order) are common
        case ($urandom_range(3))
            0: p = 16'(0);
            1: p = 16'($urandom_range(3));
            2: p = 16'hFFFF;
            default: p = 16'($urandom);
        endcase
        send_beat(cmd, $urandom, p, 1'b0, '0);
    endtask

    row_t dir_rows[$];

    function automatic row_t mk(logic [1:0] c, logic [31:0] d, logic [15:0] p,
                                bit t, logic [1:0] s, logic [31:0] rd,
                                logic [15:0] rp, logic [6:0] n);
        row_t r;
        r.cmd = c; r.data = d; r.prio = p; r.typed = t;
        r.res.st = s; r.res.data = rd; r.res.prio = rp; r.res.cnt = n;
        return r;
    endfunction

    // ---------------- stimulus ----------------
    initial
    begin
        in_valid    = 1'b0;
        command     = CMD_PEEK;
        data_in     = '0;
        priority_in = '0;
        rst_n       = 1'b0;
        errors      = 0;
        held_n      = 0;
        long_hold   = 1'b0;
        stim_done   = 1'b0;

        // empty-store cases, extremes, ties, unused code
        dir_rows.push_back(mk(CMD_DEQ,  32'h0, 16'h0, 1, ST_EMPTY, 0, 0, 0));
        dir_rows.push_back(mk(CMD_PEEK, 32'h0, 16'h0, 1, ST_EMPTY, 0, 0, 0));
        dir_rows.push_back(mk(2'(CMD_ODD), 32'hFFFF_FFFF, 16'hFFFF, 1, ST_EMPTY, 0, 0, 0));
        dir_rows.push_back(mk(CMD_ENQ, 32'hFFFF_FFFF, 16'h0, 1, ST_OK, 0, 0, 1));
        dir_rows.push_back(mk(CMD_PEEK, 0, 0, 1, ST_OK, 32'hFFFF_FFFF, 0, 1));
        dir_rows.push_back(mk(CMD_ENQ, 32'h0, 16'hFFFF, 1, ST_OK, 0, 0, 2));
        dir_rows.push_back(mk(CMD_PEEK, 0, 0, 1, ST_OK, 0, 16'hFFFF, 2));
        dir_rows.push_back(mk(CMD_ENQ, 32'hA5A5_0001, 16'h0005, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(CMD_ENQ, 32'hA5A5_0002, 16'h0005, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(CMD_ENQ, 32'h5A5A_0003, 16'h0005, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(CMD_ENQ, 32'h1234_5678, 16'h0000, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(2'(CMD_ODD), 0, 0, 1, ST_OK, 0, 16'hFFFF, 6));
        for (int i = 0; i < 7; i++)
            dir_rows.push_back(mk(CMD_DEQ, 0, 0, 0, 0, 0, 0, 0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].prio,
                      dir_rows[i].typed, dir_rows[i].res);
        drop_valid();
        @(posedge clk);

        // fill to capacity with the receiver held off: input must stall
        long_hold <= 1'b1;
        for (int i = 0; i < DEPTH + 3; i++)
            random_beat(100);
        drop_valid();
        @(posedge clk);
        // drain
        for (int i = 0; i < DEPTH + 3; i++)
            random_beat(0);
        drop_valid();

        // sender pauses until all results are back
        wait (pending_results.size() == 0);
        @(posedge clk);

        // random bursts with shifting fill bias
        for (int phase = 0; phase < 6; phase++)
        begin
            int bias;
            int sent;
            bias = (phase % 2 == 0) ? 70 : 30;
            sent = 0;
            while (sent < 45)
            begin
                int burst;
                burst = $urandom_range(1, 12);
                for (int k = 0; k < burst; k++)
                    random_beat(bias);
                sent += burst;
                if ($urandom_range(2) != 0)
                begin
                    drop_valid();
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
            end
        end
        drop_valid();
        stim_done = 1'b1;
    end

    // receiver: own stall pattern, one long counted hold, stall-free stretches
    initial
    begin
        int hold_cnt;
        bit hold_taken;
        hold_cnt   = 0;
        hold_taken = 1'b0;
        out_stall  = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold && !hold_taken)
            begin
                out_stall <= 1'b1;
                hold_cnt++;
                if (hold_cnt >= HOLD_CYCLES)
                    hold_taken = 1'b1;
            end
            else if (cycles % 600 < 150)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(3) == 0);
        end
    end

    // scoreboard on accepted result beats
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat st=%0d data=%h prio=%h cnt=%0d",
                             status, data_out, priority_out, count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st || data_out !== want.data ||
                    priority_out !== want.prio || count !== want.cnt)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("result mismatch: want st=%0d data=%h prio=%h cnt=%0d, got st=%0d data=%h prio=%h cnt=%0d",
                                 want.st, want.data, want.prio, want.cnt,
                                 status, data_out, priority_out, count);
                end
            end
        end
    end

    // end of run and timeout
    initial
    begin
        cycles = 0;
        fork
            forever
            begin
                @(posedge clk);
                cycles++;
            end
        join_none
        wait (stim_done);
        while (pending_results.size() != 0 && cycles < CYCLE_LIMIT)
            @(posedge clk);
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            repeat (DEPTH + 20) @(posedge clk);
            if (errors == 0)
                $display("SCOREBOARD CLEAN");
            else
                $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // guard against a hang before stimulus ends
    initial
    begin
        wait (cycles >= CYCLE_LIMIT && !stim_done);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
